// ===== hw/rtl/jipd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jipd_pkg: shared codes for the joint impedance PD controller
// Action, status and control register index codes, fixed field widths.
// ----------------------------------------------------------------------------
package jipd_pkg;

   localparam int CSR_W      = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int GAIN_W     = 16;

   localparam logic [1:0] ACT_CONTROL = 2'd0;
   localparam logic [1:0] ACT_COMMAND = 2'd1;
   localparam logic [1:0] ACT_SYNC    = 2'd2;

   localparam logic [1:0] ST_TORQUE = 2'd0;
   localparam logic [1:0] ST_ACCEPT = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_K_LO   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_K_HI   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_D_LO   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_D_HI   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLEN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_POSTOL = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TSTEP  = 3'd6;

   localparam logic [4:0]  FLEN_RESET   = 5'd1;
   localparam logic [30:0] POSTOL_RESET = 31'd1677722;
   localparam logic [30:0] TSTEP_RESET  = 31'd65536;

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_SUM   = 10'b0000000100,
      S_DIV   = 10'b0000001000,
      S_MUL1  = 10'b0000010000,
      S_MUL2  = 10'b0000100000,
      S_RND   = 10'b0001000000,
      S_OUT   = 10'b0010000000,
      S_CMD   = 10'b0100000000,
      S_FILL  = 10'b1000000000
   } state_type;

endpackage : jipd_pkg
`default_nettype wire

// ===== hw/rtl/joint_impedance_pd_controller_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joint_impedance_pd_controller_unit: seven-joint PD impedance controller
// Per-joint velocity moving average kept in a window memory with running
// sums; torque = k*(cmd - pos) - d*avg, rate limited and saturated.
//
// Usage:
//  - req_* carries one joint transaction: control, command or sync.
//  - rsp_* returns one transaction for each control item with a valid joint
//    and for the last command item of a group; nothing else answers.
//  - csr_* writes a register at any clock edge with csr_wen high; write only
//    while the block is idle. A filter_length write starts a clearing pass.
//  - Control item: S_SUM, S_DIV, S_MUL1, S_MUL2, S_RND and S_OUT in turn;
//    the serial restoring divider for the average, one quotient bit a
//    cycle, runs in S_DIV.
//  - Command item: S_CMD, which answers only for the last of a group. Sync
//    item: S_FILL, one window memory write per cycle. Items are taken one
//    at a time (req_stall low in idle).
//  - Reset and a filter_length write sweep the window memory, one entry a
//    cycle, MAX_WINDOW*JOINT_COUNT entries (112 at defaults), req_stall high.
//  - The result sits in an output register; while rsp_stall is high it
//    holds, the next item is still taken and waits only to post its result.
// ----------------------------------------------------------------------------
module joint_impedance_pd_controller_unit
   import jipd_pkg::*;
#(
   parameter int MAX_WINDOW  = 16,
   parameter int JOINT_COUNT = 7
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire  [1:0]           req_action,
   input  wire  [2:0]           req_joint,
   input  wire  signed [31:0]   req_position,
   input  wire  signed [31:0]   req_velocity,
   input  wire  signed [31:0]   req_last_torque,
   input  wire                  req_last_of_group,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [2:0]           rsp_joint_out,
   output logic signed [31:0]   rsp_torque,
   output logic [1:0]           rsp_status,
   input  wire                  csr_wen,
   input  wire  [CSR_IDX_W-1:0] csr_index,
   input  wire  [CSR_W-1:0]     csr_wdata
);

   localparam int DEPTH  = MAX_WINDOW * JOINT_COUNT;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W  = ((LEN_W > 5) ? LEN_W : 5) + 1;
   localparam int JW     = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
   localparam int SUM_W  = 32 + $clog2(MAX_WINDOW);
   localparam int DCNT_W = $clog2(SUM_W + 1);
   localparam int T_W    = SUM_W + 18;
   localparam int TR_W   = T_W - 12;
   localparam logic [3:0] JCNT = 4'(JOINT_COUNT);

   state_type state_ff;

   logic [63:0]        k_lo_ff, d_lo_ff;
   logic [47:0]        k_hi_ff, d_hi_ff;
   logic [4:0]         flen_ff;
   logic [30:0]        postol_ff, tstep_ff;

   logic signed [31:0]      cmd_ff [JOINT_COUNT];
   logic signed [31:0]      stg_ff [JOINT_COUNT];
   logic [JOINT_COUNT-1:0]  stg_valid_ff;
   logic                    stg_ok_ff;
   logic signed [SUM_W-1:0] sum_ff [JOINT_COUNT];
   logic [PTR_W-1:0]        ptr_ff;

   logic signed [31:0] vel_mem [DEPTH];
   logic signed [31:0] mem_rd_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic signed [31:0] mem_wdata;

   logic [1:0]         act_ff;
   logic [2:0]         joint_ff;
   logic signed [31:0] pos_ff, vel_ff, last_ff;
   logic               lastg_ff;
   logic [AW-1:0]      slot_ff, fill_addr_ff;
   logic [LEN_W-1:0]   fill_cnt_ff;

   logic [SUM_W-1:0]   div_quo_ff;
   logic [LEN_W-1:0]   div_rem_ff;
   logic [DCNT_W-1:0]  div_cnt_ff;
   logic               div_neg_ff;

   logic signed [49:0]       pk_ff;
   logic signed [SUM_W+16:0] pd_ff;
   logic signed [TR_W-1:0]   t_ff;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_joint_ff;
   logic signed [31:0] rsp_torque_ff;
   logic [1:0]         rsp_status_ff;

   logic [LEN_W-1:0]   len;
   logic               req_take, out_free, jvalid, req_jvalid;
   logic [JW-1:0]      jidx;
   logic [AW-1:0]      req_slot;
   logic               ptr_wrap;
   logic signed [SUM_W-1:0] new_sum, avg;
   logic [LEN_W:0]     rem_sh;
   logic               div_ge;
   logic [LEN_W-1:0]   rem_in;
   logic [111:0]       k_all, d_all;
   logic [GAIN_W-1:0]  k_gain, d_gain;
   logic signed [32:0] err, pdiff;
   logic [32:0]        pabs;
   logic               cmd_ok, ok_all;
   logic signed [T_W-1:0]  t28, trnd;
   logic signed [TR_W-1:0] lo_lim, hi_lim, tcl;
   logic signed [31:0]     tsat;

   // ------------------------------------------------------------------
   always_comb begin
      if (flen_ff == 5'd0) begin
         len = LEN_W'(1);
      end else if (CMP_W'(flen_ff) > CMP_W'(MAX_WINDOW)) begin
         len = LEN_W'(MAX_WINDOW);
      end else begin
         len = LEN_W'(flen_ff);
      end
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign jvalid     = {1'b0, joint_ff} < JCNT;
   assign req_jvalid = {1'b0, req_joint} < JCNT;
   assign jidx       = joint_ff[JW-1:0];
   assign req_slot   = AW'(ptr_ff) * AW'(JOINT_COUNT) + AW'(req_joint);
   assign ptr_wrap   = (LEN_W'(ptr_ff) + LEN_W'(1)) >= len;

   assign new_sum = sum_ff[jidx] + SUM_W'(vel_ff) - SUM_W'(mem_rd_ff);

   assign rem_sh = {div_rem_ff, div_quo_ff[SUM_W-1]};
   assign div_ge = rem_sh >= {1'b0, len};
   assign rem_in = div_ge ? LEN_W'(rem_sh - {1'b0, len}) : LEN_W'(rem_sh);
   assign avg    = div_neg_ff ? -$signed(div_quo_ff) : $signed(div_quo_ff);

   assign k_all  = {k_hi_ff, k_lo_ff};
   assign d_all  = {d_hi_ff, d_lo_ff};
   assign k_gain = k_all[{joint_ff, 4'b0000} +: GAIN_W];
   assign d_gain = d_all[{joint_ff, 4'b0000} +: GAIN_W];
   assign err    = 33'(cmd_ff[jidx]) - 33'(pos_ff);

   assign pdiff  = 33'(pos_ff) - 33'(cmd_ff[jidx]);
   assign pabs   = pdiff[32] ? 33'(-pdiff) : 33'(pdiff);
   assign cmd_ok = jvalid && (pabs <= {2'b00, postol_ff});
   assign ok_all = stg_ok_ff && cmd_ok;

   assign t28    = T_W'(pk_ff) - T_W'(pd_ff) + T_W'(2048);
   assign trnd   = t28 >>> 12;
   assign lo_lim = TR_W'(last_ff) - TR_W'($signed({1'b0, tstep_ff}));
   assign hi_lim = TR_W'(last_ff) + TR_W'($signed({1'b0, tstep_ff}));

   always_comb begin
      tcl = t_ff;
      if (tcl < lo_lim) begin
         tcl = lo_lim;
      end
      if (tcl > hi_lim) begin
         tcl = hi_lim;
      end
      if (tcl > TR_W'(32'sh7FFFFFFF)) begin
         tsat = 32'sh7FFFFFFF;
      end else if (tcl < TR_W'(-33'sh080000000)) begin
         tsat = 32'sh80000000;
      end else begin
         tsat = 32'(tcl);
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = fill_addr_ff;
      mem_wdata = vel_ff;
      unique case (state_ff)
         S_SUM: begin
            mem_we    = 1'b1;
            mem_waddr = slot_ff;
         end
         S_FILL: begin
            mem_we = 1'b1;
         end
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vel_mem[mem_waddr] <= mem_wdata;
      end
      if (req_take) begin
         mem_rd_ff <= vel_mem[req_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         act_ff   <= req_action;
         joint_ff <= req_joint;
         pos_ff   <= req_position;
         vel_ff   <= req_velocity;
         last_ff  <= req_last_torque;
         lastg_ff <= req_last_of_group;
         slot_ff  <= req_slot;
      end
      if (state_ff == S_MUL1) begin
         pk_ff <= err * $signed({1'b0, k_gain});
      end
      if (state_ff == S_MUL2) begin
         pd_ff <= avg * $signed({1'b0, d_gain});
      end
      if (state_ff == S_RND) begin
         t_ff <= TR_W'(trnd);
      end
      if (state_ff == S_CMD && jvalid) begin
         stg_ff[jidx] <= pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         k_lo_ff       <= '0;
         k_hi_ff       <= '0;
         d_lo_ff       <= '0;
         d_hi_ff       <= '0;
         flen_ff       <= FLEN_RESET;
         postol_ff     <= POSTOL_RESET;
         tstep_ff      <= TSTEP_RESET;
         stg_valid_ff  <= '0;
         stg_ok_ff     <= 1'b1;
         ptr_ff        <= '0;
         fill_addr_ff  <= '0;
         fill_cnt_ff   <= '0;
         div_quo_ff    <= '0;
         div_rem_ff    <= '0;
         div_cnt_ff    <= '0;
         div_neg_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_joint_ff  <= '0;
         rsp_torque_ff <= '0;
         rsp_status_ff <= ST_TORQUE;
         for (int i = 0; i < JOINT_COUNT; i++) begin
            cmd_ff[i] <= '0;
            sum_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wen) begin
            unique case (csr_index)
               CSR_K_LO:   k_lo_ff   <= csr_wdata;
               CSR_K_HI:   k_hi_ff   <= csr_wdata[47:0];
               CSR_D_LO:   d_lo_ff   <= csr_wdata;
               CSR_D_HI:   d_hi_ff   <= csr_wdata[47:0];
               CSR_FLEN:   flen_ff   <= csr_wdata[4:0];
               CSR_POSTOL: postol_ff <= csr_wdata[30:0];
               CSR_TSTEP:  tstep_ff  <= csr_wdata[30:0];
               default:    k_lo_ff   <= k_lo_ff;
            endcase
         end
         unique case (state_ff)
            S_CLEAR: begin
               ptr_ff       <= '0;
               fill_addr_ff <= fill_addr_ff + AW'(1);
               for (int i = 0; i < JOINT_COUNT; i++) begin
                  sum_ff[i] <= '0;
               end
               if (fill_addr_ff == AW'(DEPTH - 1)) begin
                  fill_addr_ff <= '0;
                  state_ff     <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (csr_wen && csr_index == CSR_FLEN) begin
                  fill_addr_ff <= '0;
                  state_ff     <= S_CLEAR;
               end else if (req_take) begin
                  case (req_action)
                     ACT_CONTROL: begin
                        if (req_jvalid) begin
                           state_ff <= S_SUM;
                        end else if (req_last_of_group) begin
                           ptr_ff <= ptr_wrap ? '0 : ptr_ff + PTR_W'(1);
                        end
                     end
                     ACT_COMMAND: begin
                        state_ff <= S_CMD;
                     end
                     ACT_SYNC: begin
                        if (req_last_of_group) begin
                           ptr_ff <= '0;
                        end
                        if (req_jvalid) begin
                           cmd_ff[req_joint[JW-1:0]] <= req_position;
                           sum_ff[req_joint[JW-1:0]] <=
                              SUM_W'(req_velocity) * SUM_W'($signed({1'b0, len}));
                           fill_addr_ff <= AW'(req_joint);
                           fill_cnt_ff  <= '0;
                           state_ff     <= S_FILL;
                        end
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_SUM: begin
               sum_ff[jidx] <= new_sum;
               div_neg_ff   <= new_sum[SUM_W-1];
               div_quo_ff   <= new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);
               div_rem_ff   <= '0;
               div_cnt_ff   <= '0;
               state_ff     <= S_DIV;
            end
            S_DIV: begin
               div_quo_ff <= {div_quo_ff[SUM_W-2:0], div_ge};
               div_rem_ff <= rem_in;
               div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
               if (div_cnt_ff == DCNT_W'(SUM_W - 1)) begin
                  state_ff <= S_MUL1;
               end
            end
            S_MUL1: state_ff <= S_MUL2;
            S_MUL2: state_ff <= S_RND;
            S_RND:  state_ff <= S_OUT;
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_joint_ff  <= joint_ff;
                  rsp_torque_ff <= tsat;
                  rsp_status_ff <= ST_TORQUE;
                  if (lastg_ff) begin
                     ptr_ff <= ptr_wrap ? '0 : ptr_ff + PTR_W'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_CMD: begin
               if (!lastg_ff) begin
                  stg_ok_ff <= ok_all;
                  if (jvalid) begin
                     stg_valid_ff[jidx] <= 1'b1;
                  end
                  state_ff <= S_IDLE;
               end else if (out_free) begin
                  if (ok_all) begin
                     for (int i = 0; i < JOINT_COUNT; i++) begin
                        if (jvalid && JW'(i) == jidx) begin
                           cmd_ff[i] <= pos_ff;
                        end else if (stg_valid_ff[i]) begin
                           cmd_ff[i] <= stg_ff[i];
                        end
                     end
                  end
                  rsp_valid_ff  <= 1'b1;
                  rsp_joint_ff  <= jvalid ? joint_ff : 3'd0;
                  rsp_torque_ff <= '0;
                  rsp_status_ff <= ok_all ? ST_ACCEPT : ST_REJECT;
                  stg_valid_ff  <= '0;
                  stg_ok_ff     <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_FILL: begin
               fill_addr_ff <= fill_addr_ff + AW'(JOINT_COUNT);
               fill_cnt_ff  <= fill_cnt_ff + LEN_W'(1);
               if (fill_cnt_ff + LEN_W'(1) >= len) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_joint_out = rsp_joint_ff;
   assign rsp_torque    = rsp_torque_ff;
   assign rsp_status    = rsp_status_ff;

   // ------------------------------------------------------------------
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> div_cnt_ff < DCNT_W'(SUM_W))
      else $error("divider ran past its last step");

   a_cmd_torque_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_TORQUE |-> rsp_torque_ff == '0)
      else $error("command transaction carries torque");

   a_ptr_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> LEN_W'(ptr_ff) < len)
      else $error("window pointer beyond filter length");

   a_clear_ptr: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff) == S_CLEAR && state_ff == S_IDLE |-> ptr_ff == '0)
      else $error("pointer not cleared by clearing pass");

endmodule : joint_impedance_pd_controller_unit
`default_nettype wire
